// ===== hw/rtl/cscc_pkg.sv =====
// cascaded speed/current controller: shared constants and register codes
// no dependencies; imported by the controller, cscc_checker and testbench
package cscc_pkg;

  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned SampleW   = 12;
  localparam int unsigned DutyW     = 17;
  localparam int unsigned CurMaW    = 15;
  localparam int unsigned SpdRpmW   = 11;
  localparam int unsigned RefW      = 15;
  localparam int unsigned ModeW     = 2;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMode     = 4'd0;
  localparam logic [CfgIdxW-1:0] RegRef      = 4'd1;
  localparam logic [CfgIdxW-1:0] RegCurKp    = 4'd2;
  localparam logic [CfgIdxW-1:0] RegCurKi    = 4'd3;
  localparam logic [CfgIdxW-1:0] RegSpdKp    = 4'd4;
  localparam logic [CfgIdxW-1:0] RegSpdKi    = 4'd5;
  localparam logic [CfgIdxW-1:0] RegSpdKd    = 4'd6;
  localparam logic [CfgIdxW-1:0] RegCurLimit = 4'd7;

  // operating modes
  localparam logic [ModeW-1:0] ModeStop   = 2'd0;
  localparam logic [ModeW-1:0] ModeTorque = 2'd1;
  localparam logic [ModeW-1:0] ModeSpeed  = 2'd2;

  // scaling and limits
  localparam int unsigned CurScale    = 30000;
  localparam int unsigned SpdScale    = 1400;
  localparam int          SpdIntLimit = 30000;
  localparam int          CurIntLimit = 65536;
  localparam int          DutyFull    = 65536;

endpackage

// ===== hw/rtl/cascaded_speed_current_controller.sv =====
// cascaded speed/current controller: speed pid feeding a current pi, one tick per word
// depends on cscc_pkg; single shared 33x17 signed multiplier under a small sequencer
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------------
//  in      | in        | in_valid / stall   | current_sample, speed_sample
//  out     | out       | out_valid / stall  | duty, duty_valid, current_target_ma,
//          |           |                    | speed_rpm, current_ma
//  cfg     | in        | cfg_valid / ready  | cfg_index, cfg_data
//
// from acceptance to the result register a tick steps sc, ss, err, ski, skp, skd, sout, cki,
// ckp, duty, out; torque skips ski to sout, stop jumps to out; one multiplier product a cycle.
// in_stall_o is high while a tick is worked; a result waiting on out_stall_i holds
// the sequencer in its last step but the next word is not taken until it leaves.
// reset clears the sequencer, the loop state and the configuration registers;
// cfg_ready_o is always high.
module cascaded_speed_current_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [cscc_pkg::SampleW-1:0]        current_sample_i,
  input  logic [cscc_pkg::SampleW-1:0]        speed_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [cscc_pkg::DutyW-1:0]          duty_o,
  output logic                                duty_valid_o,
  output logic [cscc_pkg::CurMaW-1:0]         current_target_ma_o,
  output logic [cscc_pkg::SpdRpmW-1:0]        speed_rpm_o,
  output logic [cscc_pkg::CurMaW-1:0]         current_ma_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cscc_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [cscc_pkg::CfgDataW-1:0]       cfg_data_i
);
  import cscc_pkg::*;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSc   = 4'd1;
  localparam logic [3:0] StSs   = 4'd2;
  localparam logic [3:0] StErr  = 4'd3;
  localparam logic [3:0] StSki  = 4'd4;
  localparam logic [3:0] StSkp  = 4'd5;
  localparam logic [3:0] StSkd  = 4'd6;
  localparam logic [3:0] StSout = 4'd7;
  localparam logic [3:0] StCki  = 4'd8;
  localparam logic [3:0] StCkp  = 4'd9;
  localparam logic [3:0] StDuty = 4'd10;
  localparam logic [3:0] StOut  = 4'd11;

  logic [3:0]             state_q, state_d;

  logic [ModeW-1:0]       mode_q;
  logic [RefW-1:0]        ref_q;
  logic [CfgDataW-1:0]    cur_kp_q, cur_ki_q, spd_kp_q, spd_ki_q, spd_kd_q;
  logic [CurMaW-1:0]      limit_q;

  logic signed [15:0]     si_q, si_d;
  logic signed [15:0]     prev_q, prev_d;
  logic signed [17:0]     ci_q, ci_d;

  logic [SampleW-1:0]     cs_q, ss_q;
  logic signed [15:0]     e_q, e_d;
  logic signed [15:0]     ec_q, ec_d;
  logic signed [49:0]     acc_q, acc_d;
  logic signed [49:0]     prod_q, prod_d;

  logic [DutyW-1:0]       duty_q, duty_d;
  logic                   dv_q, dv_d;
  logic [CurMaW-1:0]      tgt_q, tgt_d;
  logic [SpdRpmW-1:0]     spd_q, spd_d;
  logic [CurMaW-1:0]      cur_q, cur_d;

  logic                   out_valid_q;
  logic [DutyW-1:0]       o_duty_q;
  logic                   o_dv_q;
  logic [CurMaW-1:0]      o_tgt_q;
  logic [SpdRpmW-1:0]     o_spd_q;
  logic [CurMaW-1:0]      o_cur_q;

  logic signed [32:0]     mul_a;
  logic signed [16:0]     mul_b;
  logic signed [34:0]     integ_sum;
  logic signed [50:0]     acc_sum;
  logic signed [35:0]     spd_out;
  logic signed [50:0]     ci_sum;
  logic signed [50:0]     duty_sum;
  logic signed [15:0]     ec_now;
  logic                   in_acc, out_free, cfg_wr;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;

  assign integ_sum = 35'(si_q) + 35'(prod_q >>> 16);
  assign acc_sum   = 51'(acc_q) + 51'(prod_q);
  assign spd_out   = 36'(acc_sum >>> 16) + 36'(si_q);
  assign ci_sum    = 51'(ci_q) + 51'(prod_q);
  assign duty_sum  = 51'(prod_q) + 51'(ci_q);
  assign ec_now    = $signed({1'b0, tgt_q}) - $signed({1'b0, cur_q});

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      StSc: begin
        mul_a = 33'(CurScale);
        mul_b = $signed({5'b0, cs_q});
      end
      StSs: begin
        mul_a = 33'(SpdScale);
        mul_b = $signed({5'b0, ss_q});
      end
      StSki: begin
        mul_a = $signed({1'b0, spd_ki_q});
        mul_b = 17'(e_q);
      end
      StSkp: begin
        mul_a = $signed({1'b0, spd_kp_q});
        mul_b = 17'(e_q);
      end
      StSkd: begin
        mul_a = $signed({1'b0, spd_kd_q});
        mul_b = 17'(e_q) - 17'(prev_q);
      end
      StCki: begin
        mul_a = $signed({1'b0, cur_ki_q});
        mul_b = 17'(ec_now);
      end
      StCkp: begin
        mul_a = $signed({1'b0, cur_kp_q});
        mul_b = 17'(ec_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    state_d = state_q;
    si_d    = si_q;
    prev_d  = prev_q;
    ci_d    = ci_q;
    e_d     = e_q;
    ec_d    = ec_q;
    acc_d   = acc_q;
    duty_d  = duty_q;
    dv_d    = dv_q;
    tgt_d   = tgt_q;
    spd_d   = spd_q;
    cur_d   = cur_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc) state_d = StSc;
      end
      StSc: state_d = StSs;
      StSs: begin
        cur_d   = prod_q[26:12];
        state_d = StErr;
      end
      StErr: begin
        spd_d = prod_q[22:12];
        e_d   = $signed({1'b0, ref_q}) - $signed({5'b0, prod_q[22:12]});
        if (mode_q == ModeSpeed) begin
          state_d = StSki;
        end else if (mode_q == ModeTorque) begin
          tgt_d   = ref_q;
          state_d = StCki;
        end else begin
          si_d    = '0;
          prev_d  = '0;
          ci_d    = '0;
          tgt_d   = '0;
          duty_d  = '0;
          dv_d    = 1'b0;
          state_d = StOut;
        end
      end
      StSki: state_d = StSkp;
      StSkp: begin
        if (integ_sum > 35'(SpdIntLimit)) si_d = 16'(SpdIntLimit);
        else if (integ_sum < -35'(SpdIntLimit)) si_d = -16'(SpdIntLimit);
        else si_d = 16'(integ_sum);
        state_d = StSkd;
      end
      StSkd: begin
        acc_d   = prod_q;
        state_d = StSout;
      end
      StSout: begin
        if (spd_out < 36'sd0) tgt_d = '0;
        else if (spd_out > $signed({21'b0, limit_q})) tgt_d = limit_q;
        else tgt_d = spd_out[CurMaW-1:0];
        prev_d  = e_q;
        state_d = StCki;
      end
      StCki: begin
        ec_d    = ec_now;
        state_d = StCkp;
      end
      StCkp: begin
        if (ci_sum > 51'(CurIntLimit)) ci_d = 18'(CurIntLimit);
        else if (ci_sum < -51'(CurIntLimit)) ci_d = -18'(CurIntLimit);
        else ci_d = 18'(ci_sum);
        state_d = StDuty;
      end
      StDuty: begin
        if (duty_sum < 51'sd0) duty_d = '0;
        else if (duty_sum > 51'(DutyFull)) duty_d = DutyW'(DutyFull);
        else duty_d = duty_sum[DutyW-1:0];
        dv_d    = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        if (out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    // writing stop clears the loop state
    if (cfg_wr && cfg_index_i == RegMode && cfg_data_i[ModeW-1:0] == ModeStop) begin
      si_d   = '0;
      prev_d = '0;
      ci_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= '0;
      ref_q       <= '0;
      cur_kp_q    <= '0;
      cur_ki_q    <= '0;
      spd_kp_q    <= '0;
      spd_ki_q    <= '0;
      spd_kd_q    <= '0;
      limit_q     <= '0;
      si_q        <= '0;
      prev_q      <= '0;
      ci_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      si_q    <= si_d;
      prev_q  <= prev_d;
      ci_q    <= ci_d;
      if (cfg_wr) begin
        unique case (cfg_index_i)
          RegMode:     mode_q   <= cfg_data_i[ModeW-1:0];
          RegRef:      ref_q    <= cfg_data_i[RefW-1:0];
          RegCurKp:    cur_kp_q <= cfg_data_i;
          RegCurKi:    cur_ki_q <= cfg_data_i;
          RegSpdKp:    spd_kp_q <= cfg_data_i;
          RegSpdKi:    spd_ki_q <= cfg_data_i;
          RegSpdKd:    spd_kd_q <= cfg_data_i;
          RegCurLimit: limit_q  <= cfg_data_i[CurMaW-1:0];
          default: ;
        endcase
      end
      if (state_q == StOut && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    e_q    <= e_d;
    ec_q   <= ec_d;
    acc_q  <= acc_d;
    duty_q <= duty_d;
    dv_q   <= dv_d;
    tgt_q  <= tgt_d;
    spd_q  <= spd_d;
    cur_q  <= cur_d;
    if (in_acc) begin
      cs_q <= current_sample_i;
      ss_q <= speed_sample_i;
    end
    if (state_q == StOut && out_free) begin
      o_duty_q <= duty_q;
      o_dv_q   <= dv_q;
      o_tgt_q  <= tgt_q;
      o_spd_q  <= spd_q;
      o_cur_q  <= cur_q;
    end
  end

  assign in_stall_o          = (state_q != StIdle);
  assign cfg_ready_o         = 1'b1;
  assign out_valid_o         = out_valid_q;
  assign duty_o              = o_duty_q;
  assign duty_valid_o        = o_dv_q;
  assign current_target_ma_o = o_tgt_q;
  assign speed_rpm_o         = o_spd_q;
  assign current_ma_o        = o_cur_q;

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_o <= DutyW'(DutyFull))
    else $error("duty above full scale");

  a_stop_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !duty_valid_o) |-> (duty_o == '0 && current_target_ma_o == '0))
    else $error("stop word carries a duty or target");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("sequencer idle after accepting a word");

  a_ci_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ci_q <= 18'sd65536) && (ci_q >= -18'sd65536))
    else $error("current integral out of bounds");

endmodule

// ===== tb/cscc_checker.sv =====
// checker for the cascaded speed/current controller: follows the register, input and result
// channels, predicts each result word and compares it; depends on cscc_pkg
module cscc_checker
  import cscc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_o,
  input  logic [SampleW-1:0]  current_sample_i,
  input  logic [SampleW-1:0]  speed_sample_i,
  input  logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic [DutyW-1:0]    duty_o,
  input  logic                duty_valid_o,
  input  logic [CurMaW-1:0]   current_target_ma_o,
  input  logic [SpdRpmW-1:0]  speed_rpm_o,
  input  logic [CurMaW-1:0]   current_ma_o,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  mismatch_count,
  output int                  pending_count,
  output int                  results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [DutyW-1:0]   duty;
    logic               duty_valid;
    logic [CurMaW-1:0]  target_ma;
    logic [SpdRpmW-1:0] rpm;
    logic [CurMaW-1:0]  cur_ma;
  } tick_result_t;

  tick_result_t tick_q[$];

  logic [ModeW-1:0]    mode_q;
  logic [RefW-1:0]     ref_q;
  logic [CfgDataW-1:0] cur_kp_q;
  logic [CfgDataW-1:0] cur_ki_q;
  logic [CfgDataW-1:0] spd_kp_q;
  logic [CfgDataW-1:0] spd_ki_q;
  logic [CfgDataW-1:0] spd_kd_q;
  logic [RefW-1:0]     limit_q;

  logic signed [15:0] spd_int_q;
  logic signed [15:0] prev_err_q;
  logic signed [17:0] cur_int_q;

  int errs;
  int seen;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic tick_result_t predict_tick(input logic [SampleW-1:0] cs,
                                                input logic [SampleW-1:0] ss);
    longint cur_ma;
    longint rpm;
    longint err;
    longint integ;
    longint loop_out;
    longint target;
    longint ec;
    longint ci;
    longint duty;
    tick_result_t r;
    cur_ma = (longint'(CurScale) * longint'(cs)) >>> 12;
    rpm    = (longint'(SpdScale) * longint'(ss)) >>> 12;
    target = 0;
    duty   = 0;
    if (mode_q == ModeSpeed || mode_q == ModeTorque) begin
      if (mode_q == ModeSpeed) begin
        err   = longint'(ref_q) - rpm;
        integ = longint'(spd_int_q) + ((longint'(spd_ki_q) * err) >>> 16);
        integ = clip(integ, -longint'(SpdIntLimit), longint'(SpdIntLimit));
        loop_out = ((longint'(spd_kp_q) * err
                     + longint'(spd_kd_q) * (err - longint'(prev_err_q))) >>> 16) + integ;
        spd_int_q  = integ[15:0];
        prev_err_q = err[15:0];
        target = clip(loop_out, 0, longint'(limit_q));
      end else begin
        target = longint'(ref_q);
      end
      ec = target - cur_ma;
      ci = clip(longint'(cur_int_q) + longint'(cur_ki_q) * ec,
                -longint'(CurIntLimit), longint'(CurIntLimit));
      cur_int_q = ci[17:0];
      duty = clip(longint'(cur_kp_q) * ec + ci, 0, longint'(DutyFull));
      r.duty_valid = 1'b1;
    end else begin
      spd_int_q    = '0;
      prev_err_q   = '0;
      cur_int_q    = '0;
      r.duty_valid = 1'b0;
    end
    r.duty      = duty[DutyW-1:0];
    r.target_ma = target[CurMaW-1:0];
    r.rpm       = rpm[SpdRpmW-1:0];
    r.cur_ma    = cur_ma[CurMaW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst_ni) begin
      mode_q     = ModeStop;
      ref_q      = '0;
      cur_kp_q   = '0;
      cur_ki_q   = '0;
      spd_kp_q   = '0;
      spd_ki_q   = '0;
      spd_kd_q   = '0;
      limit_q    = '0;
      spd_int_q  = '0;
      prev_err_q = '0;
      cur_int_q  = '0;
      tick_q.delete();
      errs = 0;
      seen = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegMode: begin
            mode_q = cfg_data_i[ModeW-1:0];
            if (mode_q == ModeStop) begin
              spd_int_q  = '0;
              prev_err_q = '0;
              cur_int_q  = '0;
            end
          end
          RegRef:      ref_q    = cfg_data_i[RefW-1:0];
          RegCurKp:    cur_kp_q = cfg_data_i;
          RegCurKi:    cur_ki_q = cfg_data_i;
          RegSpdKp:    spd_kp_q = cfg_data_i;
          RegSpdKi:    spd_ki_q = cfg_data_i;
          RegSpdKd:    spd_kd_q = cfg_data_i;
          RegCurLimit: limit_q  = cfg_data_i[RefW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        tick_q.push_back(predict_tick(current_sample_i, speed_sample_i));
      end
      if (out_valid_o && !out_stall_i) begin
        got = {duty_o, duty_valid_o, current_target_ma_o, speed_rpm_o, current_ma_o};
        seen++;
        if (tick_q.size() == 0) begin
          errs++;
          if (errs <= ReportLimit) begin
            $display("result word %0d with no tick waiting: duty %0d valid %0d target %0d",
                     seen, got.duty, got.duty_valid, got.target_ma);
          end
        end else begin
          want = tick_q.pop_front();
          if (got.duty != want.duty || got.duty_valid != want.duty_valid ||
              got.target_ma != want.target_ma || got.rpm != want.rpm ||
              got.cur_ma != want.cur_ma) begin
            errs++;
            if (errs <= ReportLimit) begin
              $display("word %0d exp/got: duty %0d/%0d valid %0d/%0d target %0d/%0d",
                       seen, want.duty, got.duty, want.duty_valid, got.duty_valid,
                       want.target_ma, got.target_ma);
              $display("  rpm %0d/%0d current %0d/%0d",
                       want.rpm, got.rpm, want.cur_ma, got.cur_ma);
            end
          end
        end
      end
    end
    mismatch_count <= errs;
    pending_count  <= tick_q.size();
    results_seen   <= seen;
  end

endmodule

// ===== tb/testbench.sv =====
// top of the cascaded speed/current controller bench: clock, reset, register writes,
// sample stimulus with idle and stall mixes, verdict; depends on cscc_pkg and cscc_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cscc_pkg::*;

  localparam logic [ModeW-1:0]   ModeSpare     = 2'd3;
  localparam logic [CfgIdxW-1:0] RegStray      = 4'd15;
  localparam int                 TickSlack     = 16;
  localparam int                 WatchdogLimit = 2000;
  localparam int                 PhaseCount    = 12;
  localparam int                 PhaseTicks    = 160;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [SampleW-1:0]  current_sample_i;
  logic [SampleW-1:0]  speed_sample_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [DutyW-1:0]    duty_o;
  logic                duty_valid_o;
  logic [CurMaW-1:0]   current_target_ma_o;
  logic [SpdRpmW-1:0]  speed_rpm_o;
  logic [CurMaW-1:0]   current_ma_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int mismatch_count;
  int pending_count;
  int results_seen;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int          ticks_sent = 0;
  int          reg_writes = 0;
  int          quiet_cycles;
  logic [SampleW-1:0] cur_walk = '0;
  logic [SampleW-1:0] spd_walk = '0;

  cascaded_speed_current_controller i_dut (.*);

  cscc_checker i_checker (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
  endtask

  task automatic finish_writes();
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_tick(input logic [SampleW-1:0] cs, input logic [SampleW-1:0] ss);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i       = 1'b1;
    current_sample_i = cs;
    speed_sample_i   = ss;
    do @(posedge clk_i); while (in_stall_o);
    ticks_sent++;
  endtask

  // sender holds off until every result word is back, then lets the sequencer go quiet
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (TickSlack) @(negedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] pick_gain();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return $urandom_range(255);
      5, 6, 7: return $urandom_range(65535);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CfgDataW-1:0] pick_level(input int unsigned span);
    case ($urandom_range(9))
      0:       return 0;
      1:       return 30000;
      2:       return 32767;
      default: return $urandom_range(span);
    endcase
  endfunction

  function automatic logic [ModeW-1:0] phase_mode(input int p);
    case (p)
      1, 6, 9: return ModeTorque;
      3:       return ModeStop;
      5:       return ModeSpare;
      default: return ModeSpeed;
    endcase
  endfunction

  function automatic logic [SampleW-1:0] drift(input logic [SampleW-1:0] x);
    int v;
    v = int'(x) + int'($urandom_range(128)) - 64;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SampleW-1:0];
  endfunction

  task automatic configure_phase(input int p);
    logic [ModeW-1:0] m;
    m = phase_mode(p);
    if ($urandom_range(2) == 0) write_reg(RegMode, CfgDataW'(ModeStop));
    write_reg(RegStray - CfgIdxW'($urandom_range(7)), $urandom());
    if (p == 3) begin
      write_reg(RegCurKp, '0);
      write_reg(RegCurKi, '0);
      write_reg(RegSpdKp, '0);
      write_reg(RegSpdKi, '0);
      write_reg(RegSpdKd, '0);
      write_reg(RegRef, '0);
      write_reg(RegCurLimit, '0);
    end else if (p == 7) begin
      write_reg(RegCurKp, '1);
      write_reg(RegCurKi, '1);
      write_reg(RegSpdKp, '1);
      write_reg(RegSpdKi, '1);
      write_reg(RegSpdKd, '1);
      write_reg(RegRef, 32767);
      write_reg(RegCurLimit, 32767);
    end else begin
      write_reg(RegCurKp, pick_gain());
      write_reg(RegCurKi, pick_gain());
      write_reg(RegSpdKp, pick_gain());
      write_reg(RegSpdKi, pick_gain());
      write_reg(RegSpdKd, pick_gain());
      write_reg(RegRef, (p == 11) ? 30000 : pick_level((m == ModeSpeed) ? 1400 : 30000));
      write_reg(RegCurLimit, (p == 11) ? 30000 : pick_level(30000));
    end
    write_reg(RegMode, CfgDataW'(m));
    finish_writes();
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    current_sample_i = '0;
    speed_sample_i   = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // stop mode straight out of reset
    send_tick(12'd0, 12'd0);
    send_tick(12'd4095, 12'd4095);

    settle();
    write_reg(RegRef, 30000);
    write_reg(RegCurKp, 4);
    write_reg(RegCurKi, 1);
    write_reg(RegSpdKp, 32'h0001_0000);
    write_reg(RegSpdKi, 32'h0000_0100);
    write_reg(RegSpdKd, 32'h0000_8000);
    write_reg(RegCurLimit, 30000);
    write_reg(RegMode, CfgDataW'(ModeTorque));
    finish_writes();
    send_tick(12'd0, 12'd0);
    send_tick(12'd4095, 12'd4095);
    send_tick(12'd2048, 12'd1024);
    send_tick(12'd0, 12'd4095);

    // reference beyond the nominal range
    settle();
    write_reg(RegRef, 32767);
    finish_writes();
    send_tick(12'd0, 12'd0);
    send_tick(12'd4095, 12'd0);

    // speed loop with a large integral gain
    settle();
    write_reg(RegRef, 1400);
    write_reg(RegSpdKi, 32'h0008_0000);
    write_reg(RegCurLimit, 20000);
    write_reg(RegMode, CfgDataW'(ModeSpeed));
    finish_writes();
    send_tick(12'd100, 12'd0);
    send_tick(12'd100, 12'd0);
    send_tick(12'd100, 12'd4095);
    send_tick(12'd4095, 12'd2048);
    send_tick(12'd0, 12'd4095);

    settle();
    write_reg(RegMode, CfgDataW'(ModeSpare));
    finish_writes();
    send_tick(12'd1000, 12'd2000);

    settle();
    write_reg(RegMode, CfgDataW'(ModeSpeed));
    finish_writes();
    send_tick(12'd0, 12'd0);
    send_tick(12'd0, 12'd0);

    // stop write clears the loops; stray index ignored; gains at full scale
    settle();
    write_reg(RegMode, CfgDataW'(ModeStop));
    write_reg(RegMode, CfgDataW'(ModeSpeed));
    write_reg(RegStray, 32'hA5A5_5A5A);
    write_reg(RegCurKp, '1);
    write_reg(RegCurKi, '1);
    write_reg(RegSpdKp, '1);
    write_reg(RegSpdKi, '1);
    write_reg(RegSpdKd, '1);
    write_reg(RegCurLimit, 32767);
    finish_writes();
    send_tick(12'd0, 12'd0);
    send_tick(12'd4095, 12'd4095);
    send_tick(12'd2048, 12'd2048);

    settle();
    write_reg(RegCurLimit, 0);
    write_reg(RegRef, 0);
    finish_writes();
    send_tick(12'd0, 12'd4095);
    send_tick(12'd4095, 12'd0);

    settle();
    write_reg(RegMode, CfgDataW'(ModeTorque));
    finish_writes();
    send_tick(12'd4095, 12'd0);

    for (int p = 0; p < PhaseCount; p++) begin
      settle();
      case (p % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 54;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 54;
        end
        default: begin
          idle_pct  = 28;
          stall_pct = 28;
        end
      endcase
      configure_phase(p);
      for (int n = 0; n < PhaseTicks; n++) begin
        cur_walk = ($urandom_range(3) == 0) ? SampleW'($urandom_range(4095)) : drift(cur_walk);
        spd_walk = ($urandom_range(3) == 0) ? SampleW'($urandom_range(4095)) : drift(spd_walk);
        send_tick(cur_walk, spd_walk);
      end
    end

    settle();
    $display("ran %0d ticks through stop, torque, speed and spare modes with %0d register writes",
             ticks_sent, reg_writes);
    $display("%0d result words checked under no idling, sender gaps, receiver stalls and both",
             results_seen);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/cscc_pkg.sv
hw/rtl/cascaded_speed_current_controller.sv
tb/cscc_checker.sv
tb/testbench.sv
